// File: sv/ibl_pkg.sv
package ibl_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int TYPE_W   = 3;
    localparam int POS_W    = 6;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [TYPE_W-1:0] {
        REQ_APPEND = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_READ   = 3'd3,
        REQ_WRITE  = 3'd4
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHUP,
        S_INSFIN,
        S_SHDN,
        S_READW,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_CAPTURE,
        DP_REJECT,
        DP_APPEND,
        DP_INSERT,
        DP_SHUP_START,
        DP_SHUP_STEP,
        DP_RM_START,
        DP_RM_STEP,
        DP_RM_STEP_LAST,
        DP_RM_LAST,
        DP_WRITE,
        DP_READ_START,
        DP_READ_TAKE,
        DP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t rej_status;
    } dp_cmd_t;

    typedef struct packed {
        req_t kind;
        logic full;
        logic pos_gt;
        logic pos_eq;
        logic pos_ge;
        logic rm_shift;
        logic up_last;
        logic dn_last;
    } dp_sts_t;

endpackage

// File: sv/indexed_byte_list_with_shift_unit.sv
// A result reaches out_valid once its request is done: read fetches the byte first, insert
// with shift first moves the bytes from position up by one, and remove with shift moves the
// bytes above position down by one. The next result waits while out_ready holds the last one.
// Throughput: one transaction at a time; the next is accepted from the cycle in which out_valid rises,
// the shift moving one byte per cycle through the single write / single read port.
// Reset (rst_n, async, active low) empties the list; element memory is not cleared.
module indexed_byte_list_with_shift_unit #(
    parameter int CAPACITY = ibl_pkg::CAPACITY_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ibl_pkg::TYPE_W-1:0]   req_type,
    input  logic [ibl_pkg::POS_W-1:0]    position,
    input  logic [ibl_pkg::BYTE_W-1:0]   byte_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ibl_pkg::BYTE_W-1:0]   byte_out,
    output logic [ibl_pkg::STATUS_W-1:0] status,
    output logic [ibl_pkg::COUNT_W-1:0]  count_now
);

    ibl_pkg::dp_cmd_t cmd;
    ibl_pkg::dp_sts_t sts;

    ibl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ibl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_type  (req_type),
        .position  (position),
        .byte_in   (byte_in),
        .cmd       (cmd),
        .sts       (sts),
        .byte_out  (byte_out),
        .status    (status),
        .count_now (count_now)
    );

endmodule

// File: sv/ibl_datapath.sv
module ibl_datapath #(
    parameter int CAPACITY = ibl_pkg::CAPACITY_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [ibl_pkg::TYPE_W-1:0]   req_type,
    input  logic [ibl_pkg::POS_W-1:0]    position,
    input  logic [ibl_pkg::BYTE_W-1:0]   byte_in,
    input  ibl_pkg::dp_cmd_t             cmd,
    output ibl_pkg::dp_sts_t             sts,
    output logic [ibl_pkg::BYTE_W-1:0]   byte_out,
    output logic [ibl_pkg::STATUS_W-1:0] status,
    output logic [ibl_pkg::COUNT_W-1:0]  count_now
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = ((CW > ibl_pkg::POS_W) ? CW : ibl_pkg::POS_W) + 1;

    logic [ibl_pkg::BYTE_W-1:0] store_mem [CAPACITY];
    logic [ibl_pkg::BYTE_W-1:0] rd_data_reg;

    ibl_pkg::req_t               kind_reg, kind_next;
    logic [ibl_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [ibl_pkg::BYTE_W-1:0]  byte_reg, byte_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [AW-1:0]               ptr_reg, ptr_next;
    logic [ibl_pkg::BYTE_W-1:0]  res_byte_reg, res_byte_next;
    ibl_pkg::status_t            res_status_reg, res_status_next;
    logic [ibl_pkg::BYTE_W-1:0]  byte_out_reg, byte_out_next;
    ibl_pkg::status_t            status_reg, status_next;
    logic [ibl_pkg::COUNT_W-1:0] count_now_reg, count_now_next;

    logic                        we, re;
    logic [AW-1:0]               waddr, raddr;
    logic [ibl_pkg::BYTE_W-1:0]  wdata;

    logic [EW-1:0] pos_x, cnt_x, ptr_x;
    logic [AW-1:0] pos_addr, cnt_addr;

    assign pos_x    = EW'(pos_reg);
    assign cnt_x    = EW'(count_reg);
    assign ptr_x    = EW'(ptr_reg);
    assign pos_addr = AW'(pos_x);
    assign cnt_addr = AW'(cnt_x);

    always_comb
    begin
        sts.kind     = kind_reg;
        sts.full     = (count_reg == CW'(CAPACITY));
        sts.pos_gt   = (pos_x > cnt_x);
        sts.pos_eq   = (pos_x == cnt_x);
        sts.pos_ge   = (pos_x >= cnt_x);
        sts.rm_shift = ((pos_x + EW'(1)) < cnt_x);
        sts.up_last  = ((ptr_x - EW'(1)) == pos_x);
        sts.dn_last  = ((ptr_x + EW'(2)) >= cnt_x);
    end

    always_comb
    begin
        kind_next       = kind_reg;
        pos_next        = pos_reg;
        byte_next       = byte_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        res_byte_next   = res_byte_reg;
        res_status_next = res_status_reg;
        byte_out_next   = byte_out_reg;
        status_next     = status_reg;
        count_now_next  = count_now_reg;
        we              = 1'b0;
        re              = 1'b0;
        waddr           = pos_addr;
        raddr           = pos_addr;
        wdata           = byte_reg;
        case (cmd.op)
            ibl_pkg::DP_CAPTURE:
            begin
                kind_next       = ibl_pkg::req_t'(req_type);
                pos_next        = position;
                byte_next       = byte_in;
                res_byte_next   = '0;
                res_status_next = ibl_pkg::STAT_OK;
            end
            ibl_pkg::DP_REJECT:
            begin
                res_status_next = cmd.rej_status;
            end
            ibl_pkg::DP_APPEND:
            begin
                we         = 1'b1;
                waddr      = cnt_addr;
                count_next = count_reg + CW'(1);
            end
            ibl_pkg::DP_INSERT:
            begin
                we         = 1'b1;
                count_next = count_reg + CW'(1);
            end
            ibl_pkg::DP_SHUP_START:
            begin
                ptr_next = cnt_addr;
                re       = 1'b1;
                raddr    = cnt_addr - AW'(1);
            end
            // move one byte up, fetch the one below it
            ibl_pkg::DP_SHUP_STEP:
            begin
                we       = 1'b1;
                waddr    = ptr_reg;
                wdata    = rd_data_reg;
                ptr_next = ptr_reg - AW'(1);
                re       = 1'b1;
                raddr    = ptr_reg - AW'(2);
            end
            ibl_pkg::DP_RM_START:
            begin
                ptr_next = pos_addr;
                re       = 1'b1;
                raddr    = pos_addr + AW'(1);
            end
            ibl_pkg::DP_RM_STEP,
            ibl_pkg::DP_RM_STEP_LAST:
            begin
                we       = 1'b1;
                waddr    = ptr_reg;
                wdata    = rd_data_reg;
                ptr_next = ptr_reg + AW'(1);
                re       = 1'b1;
                raddr    = ptr_reg + AW'(2);
                if (cmd.op == ibl_pkg::DP_RM_STEP_LAST)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            ibl_pkg::DP_RM_LAST:
            begin
                count_next = count_reg - CW'(1);
            end
            ibl_pkg::DP_WRITE:
            begin
                we = 1'b1;
            end
            ibl_pkg::DP_READ_START:
            begin
                re = 1'b1;
            end
            ibl_pkg::DP_READ_TAKE:
            begin
                res_byte_next = rd_data_reg;
            end
            ibl_pkg::DP_LOAD_OUT:
            begin
                byte_out_next  = res_byte_reg;
                status_next    = res_status_reg;
                count_now_next = ibl_pkg::COUNT_W'(count_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= store_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        pos_reg        <= pos_next;
        byte_reg       <= byte_next;
        ptr_reg        <= ptr_next;
        res_byte_reg   <= res_byte_next;
        res_status_reg <= res_status_next;
        byte_out_reg   <= byte_out_next;
        status_reg     <= status_next;
        count_now_reg  <= count_now_next;
    end

    assign byte_out  = byte_out_reg;
    assign status    = status_reg;
    assign count_now = count_now_reg;

endmodule

// File: sv/ibl_ctrl.sv
module ibl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  ibl_pkg::dp_sts_t sts,
    output ibl_pkg::dp_cmd_t cmd
);

    ibl_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ibl_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.op         = ibl_pkg::DP_NONE;
        cmd.rej_status = ibl_pkg::STAT_RANGE;
        case (state_reg)
            ibl_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = ibl_pkg::DP_CAPTURE;
                    state_next = ibl_pkg::S_DECODE;
                end
            end
            ibl_pkg::S_DECODE:
            begin
                state_next = ibl_pkg::S_DONE;
                case (sts.kind)
                    ibl_pkg::REQ_APPEND:
                    begin
                        if (sts.full)
                        begin
                            cmd.op         = ibl_pkg::DP_REJECT;
                            cmd.rej_status = ibl_pkg::STAT_FULL;
                        end
                        else
                        begin
                            cmd.op = ibl_pkg::DP_APPEND;
                        end
                    end
                    ibl_pkg::REQ_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd.op         = ibl_pkg::DP_REJECT;
                            cmd.rej_status = ibl_pkg::STAT_FULL;
                        end
                        else if (sts.pos_gt)
                        begin
                            cmd.op = ibl_pkg::DP_REJECT;
                        end
                        else if (sts.pos_eq)
                        begin
                            cmd.op = ibl_pkg::DP_INSERT;
                        end
                        else
                        begin
                            cmd.op     = ibl_pkg::DP_SHUP_START;
                            state_next = ibl_pkg::S_SHUP;
                        end
                    end
                    ibl_pkg::REQ_REMOVE:
                    begin
                        if (sts.pos_ge)
                        begin
                            cmd.op = ibl_pkg::DP_REJECT;
                        end
                        else if (sts.rm_shift)
                        begin
                            cmd.op     = ibl_pkg::DP_RM_START;
                            state_next = ibl_pkg::S_SHDN;
                        end
                        else
                        begin
                            cmd.op = ibl_pkg::DP_RM_LAST;
                        end
                    end
                    ibl_pkg::REQ_READ:
                    begin
                        if (sts.pos_ge)
                        begin
                            cmd.op = ibl_pkg::DP_REJECT;
                        end
                        else
                        begin
                            cmd.op     = ibl_pkg::DP_READ_START;
                            state_next = ibl_pkg::S_READW;
                        end
                    end
                    ibl_pkg::REQ_WRITE:
                    begin
                        if (sts.pos_ge)
                        begin
                            cmd.op = ibl_pkg::DP_REJECT;
                        end
                        else
                        begin
                            cmd.op = ibl_pkg::DP_WRITE;
                        end
                    end
                    default:
                    begin
                        cmd.op = ibl_pkg::DP_REJECT;
                    end
                endcase
            end
            ibl_pkg::S_SHUP:
            begin
                cmd.op = ibl_pkg::DP_SHUP_STEP;
                if (sts.up_last)
                begin
                    state_next = ibl_pkg::S_INSFIN;
                end
            end
            ibl_pkg::S_INSFIN:
            begin
                cmd.op     = ibl_pkg::DP_INSERT;
                state_next = ibl_pkg::S_DONE;
            end
            ibl_pkg::S_SHDN:
            begin
                if (sts.dn_last)
                begin
                    cmd.op     = ibl_pkg::DP_RM_STEP_LAST;
                    state_next = ibl_pkg::S_DONE;
                end
                else
                begin
                    cmd.op = ibl_pkg::DP_RM_STEP;
                end
            end
            ibl_pkg::S_READW:
            begin
                cmd.op     = ibl_pkg::DP_READ_TAKE;
                state_next = ibl_pkg::S_DONE;
            end
            ibl_pkg::S_DONE:
            begin
                // output register free, or emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = ibl_pkg::DP_LOAD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ibl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ibl_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule
